@@ design/bae_pkg.sv @@
// Shared types and constants for the binary arithmetic encoder.
package bae_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int RANGE_W  = 32;
    localparam int PROB_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [RANGE_W-1:0] LOW_RESET  = 32'h0000_0000;
    localparam logic [RANGE_W-1:0] HIGH_RESET = 32'hffff_ffff;
    localparam logic [BYTE_W-1:0]  FILL_BYTE  = 8'hff;

    // Drain limits per command (bytes emitted while top bytes agree)
    localparam logic [2:0] ENC_DRAIN_MAX = 3'd4;
    localparam logic [2:0] FIN_DRAIN_MAX = 3'd3;

    typedef struct packed {
        logic                is_finish;
        logic [PROB_W-1:0]   prob_one;
        logic                bit_value;
    } t_bae_item;

    typedef struct packed {
        logic      valid;
        t_bae_item item;
    } t_bae_head;

    typedef struct packed {
        logic busy;
    } t_bae_status;

endpackage

@@ design/bae_front.sv @@
// Front end: takes input beats, decodes the command and queues items for the back end.
module bae_front #(
    parameter int QUEUE_DEPTH = bae_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: prob_one [15:0], bit_value [16], zero pad [23:17]
    input  logic [bae_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: command [0]
    input  logic                          s_axis_tuser,
    input  logic                          i_pop,
    output bae_pkg::t_bae_head            o_head
);
    import bae_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bae_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    t_bae_item              w_item;
    logic                   w_push;

    assign s_axis_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_item.is_finish = (s_axis_tuser == CMD_FINISH);
        w_item.prob_one  = s_axis_tdata[PROB_W-1:0];
        w_item.bit_value = s_axis_tdata[PROB_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

@@ design/bae_back.sv @@
// Back end: interval split, renormalization and byte output register.
module bae_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bae_pkg::t_bae_head             i_head,
    output logic                           o_pop,
    output bae_pkg::t_bae_status           o_status,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: out_byte [7:0]
    output logic [bae_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import bae_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_MID   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;

    logic [2:0]          r_state;
    logic [RANGE_W-1:0]  r_low;
    logic [RANGE_W-1:0]  r_high;
    logic [RANGE_W-1:0]  r_d;
    logic [RANGE_W-1:0]  r_hi_part;
    logic [PROB_W-1:0]   r_lo_part;
    logic [PROB_W-1:0]   r_prob;
    logic                r_bit;
    logic                r_finish;
    logic [2:0]          r_cnt;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;

    logic [RANGE_W-1:0]  w_lo_prod;
    logic [RANGE_W-1:0]  w_mid;
    logic                w_agree;
    logic                w_can_emit;
    logic [2:0]          w_limit;
    logic                w_emit;

    assign w_lo_prod  = RANGE_W'(r_d[PROB_W-1:0]) * RANGE_W'(r_prob);
    assign w_mid      = r_low + r_hi_part + RANGE_W'(r_lo_part);
    assign w_agree    = (r_low[31:24] == r_high[31:24]);
    assign w_can_emit = !r_out_valid || m_axis_tready;
    assign w_limit    = r_finish ? FIN_DRAIN_MAX : ENC_DRAIN_MAX;
    // a byte is loaded into the output register this cycle
    assign w_emit     = ((r_state == ST_DRAIN) && w_agree && (r_cnt < w_limit) && w_can_emit) ||
                        ((r_state == ST_FINAL) && w_can_emit);

    assign o_pop         = (r_state == ST_IDLE) && i_head.valid;
    assign o_status.busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_low       <= LOW_RESET;
            r_high      <= HIGH_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_finish    <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_finish <= i_head.item.is_finish;
                        r_prob   <= i_head.item.prob_one;
                        r_bit    <= i_head.item.bit_value;
                        r_d      <= r_high - r_low;
                        r_cnt    <= '0;
                        r_state  <= i_head.item.is_finish ? ST_DRAIN : ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_hi_part <= RANGE_W'(r_d[31:16]) * RANGE_W'(r_prob);
                    r_lo_part <= w_lo_prod[31:16];
                    r_state   <= ST_MID;
                end
                ST_MID: begin
                    if (r_bit) begin
                        r_high <= w_mid;
                    end else begin
                        r_low <= w_mid + 1'b1;
                    end
                    r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (w_agree && (r_cnt < w_limit)) begin
                        if (w_can_emit) begin
                            r_out_byte  <= r_high[31:24];
                            // last byte of an encode: limit reached or next bytes differ
                            r_out_last  <= !r_finish &&
                                           ((r_cnt == ENC_DRAIN_MAX - 3'd1) ||
                                            (r_low[23:16] != r_high[23:16]));
                            r_low       <= {r_low[23:0], 8'h00};
                            r_high      <= {r_high[23:0], FILL_BYTE};
                            r_cnt       <= r_cnt + 3'd1;
                        end
                    end else begin
                        r_state <= r_finish ? ST_FINAL : ST_IDLE;
                    end
                end
                ST_FINAL: begin
                    if (w_can_emit) begin
                        r_out_byte  <= r_high[31:24];
                        r_out_last  <= 1'b1;
                        r_low       <= LOW_RESET;
                        r_high      <= HIGH_RESET;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ design/binary_arithmetic_encoder_top.sv @@
// Top level of the carry-less binary arithmetic encoder.
//
// Input stream (s_axis): one beat per item. tuser is the command (0 encode a bit,
// 1 finish and flush); tdata carries the probability of a one and the bit.
// Output stream (m_axis): one beat per compressed byte; tlast marks the final
// byte caused by an input item. An encode item gives 0 to 4 bytes, a finish
// item 1 to 4 bytes and then returns the interval to its start values.
// Items enter a queue of QUEUE_DEPTH entries, so input beats are taken while
// the back end works or the receiver stalls; s_axis_tready drops when it fills.
// In the back end an encode item passes through the difference, two 16x16
// partial products and the midpoint add, then the drain; a finish goes
// through the drain to the final byte. The drain emits one byte per cycle
// at the output register while the receiver does not stall.
// When the receiver stalls, the output register holds its byte and the back
// end waits; the queue keeps accepting until full.
// Reset (synchronous, active low) empties the queue, clears the output and
// sets the interval to low = 0, high = all ones.
module binary_arithmetic_encoder_top #(
    parameter int QUEUE_DEPTH = bae_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: prob_one [15:0], bit_value [16], zero pad [23:17]
    input  logic [bae_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command [0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: out_byte [7:0]
    output logic [bae_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import bae_pkg::*;

    t_bae_head   w_head;
    t_bae_status w_status;
    logic        w_pop;

    bae_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (w_pop),
        .o_head        (w_head)
    );

    bae_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_status      (w_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("back end popped an empty queue");

    a_pop_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> w_status.busy)
        else $error("back end did not start work after a pop");

    a_busy_blocks_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.busy |-> !w_pop)
        else $error("back end popped while busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_status.busy && !m_axis_tvalid)
        else $error("back end not idle after reset");
`endif

endmodule

@@ tb/sv/binary_arithmetic_encoder_top_test.sv @@
// Self-checking testbench for the binary arithmetic encoder stream block.
module binary_arithmetic_encoder_top_test;
    import bae_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last_of_run;
    } t_coded_byte;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_CHOKED
    } t_rx_mode;

    localparam int RANDOM_SYMBOLS = 95;
    localparam int DRAIN_CYCLES   = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: prob_one [15:0], bit_value [16], zero pad [23:17]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: command [0]
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: out_byte [7:0]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    t_bae_item          pending_symbols[$];
    t_coded_byte        expected_bytes[$];
    logic [RANGE_W-1:0] enc_low  = LOW_RESET;
    logic [RANGE_W-1:0] enc_high = HIGH_RESET;
    int                 n_errors = 0;

    logic     in_taken = 1'b0;
    int       burst_left = 1;
    int       gap_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_span_left = 0;

    binary_arithmetic_encoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void add_symbol(logic cmd, int unsigned prob, logic bit_value);
        t_bae_item sym;
        sym.is_finish = cmd;
        sym.prob_one  = prob[PROB_W-1:0];
        sym.bit_value = bit_value;
        pending_symbols.insert(pending_symbols.size(), sym);
    endfunction

    // Narrow the interval for one symbol (or flush) and queue the bytes it releases.
    function automatic void encode_symbol(t_bae_item sym);
        logic [RANGE_W-1:0] span;
        logic [RANGE_W-1:0] upper_prod;
        logic [RANGE_W-1:0] lower_prod;
        logic [RANGE_W-1:0] split;
        t_coded_byte        fresh[$];
        t_coded_byte        cb;
        int                 limit;
        if (sym.is_finish == CMD_ENCODE) begin
            span       = enc_high - enc_low;
            upper_prod = {16'b0, span[31:16]} * {16'b0, sym.prob_one};
            lower_prod = ({16'b0, span[15:0]} * {16'b0, sym.prob_one}) >> 16;
            split      = enc_low + upper_prod + lower_prod;
            if (sym.bit_value)
                enc_high = split;
            else
                enc_low = split + 32'd1;
            limit = 4;
        end else begin
            limit = 3;
        end
        while (fresh.size() < limit && enc_low[31:24] == enc_high[31:24]) begin
            cb.code_byte   = enc_high[31:24];
            cb.last_of_run = 1'b0;
            fresh.insert(fresh.size(), cb);
            enc_low  = enc_low << 8;
            enc_high = {enc_high[23:0], FILL_BYTE};
        end
        if (sym.is_finish == CMD_FINISH) begin
            cb.code_byte   = enc_high[31:24];
            cb.last_of_run = 1'b0;
            fresh.insert(fresh.size(), cb);
            enc_low  = LOW_RESET;
            enc_high = HIGH_RESET;
        end
        for (int k = 0; k < fresh.size(); k++) begin
            cb = fresh[k];
            cb.last_of_run = (k == fresh.size() - 1);
            expected_bytes.insert(expected_bytes.size(), cb);
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_symbols.size() > 0) begin
                s_axis_tdata  <= {7'b0, pending_symbols[0].bit_value,
                                  pending_symbols[0].prob_one};
                s_axis_tuser  <= pending_symbols[0].is_finish;
                s_axis_tvalid <= 1'b1;
                void'(pending_symbols.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switch between open, choppy and choked stretches.
    always @(negedge i_clk) begin
        if (rx_span_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 2));
            rx_span_left <= $urandom_range(16, 96);
        end else begin
            rx_span_left <= rx_span_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_coded_byte want;
        t_bae_item   sym;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output beat: out_byte %h last_of_run %b",
                       m_axis_tdata, m_axis_tlast);
                n_errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.code_byte) begin
                    $error("out_byte: expected %h, got %h", want.code_byte, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, m_axis_tlast);
                    n_errors++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sym.is_finish = s_axis_tuser;
            sym.prob_one  = s_axis_tdata[15:0];
            sym.bit_value = s_axis_tdata[16];
            encode_symbol(sym);
        end
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int          n_directed;
        int          frame_len;
        int unsigned prob;
        logic        bit_value;

        // Directed: flush from reset, zero and full-scale probabilities, unlikely symbols.
        add_symbol(CMD_FINISH, 16'h0000, 1'b0);
        add_symbol(CMD_ENCODE, 16'h0000, 1'b1);
        add_symbol(CMD_ENCODE, 16'h0000, 1'b0);
        add_symbol(CMD_ENCODE, 16'hffff, 1'b1);
        add_symbol(CMD_ENCODE, 16'hffff, 1'b0);
        add_symbol(CMD_ENCODE, 16'hffff, 1'b0);
        add_symbol(CMD_ENCODE, 16'hffff, 1'b0);
        add_symbol(CMD_ENCODE, 16'h0001, 1'b0);
        add_symbol(CMD_ENCODE, 16'h0001, 1'b1);
        add_symbol(CMD_ENCODE, 16'h8000, 1'b0);
        add_symbol(CMD_ENCODE, 16'h8000, 1'b1);
        add_symbol(CMD_FINISH, 16'hffff, 1'b1);
        add_symbol(CMD_ENCODE, 16'h5555, 1'b1);
        add_symbol(CMD_ENCODE, 16'haaaa, 1'b0);
        add_symbol(CMD_ENCODE, 16'h0000, 1'b1);
        add_symbol(CMD_ENCODE, 16'h0000, 1'b1);
        add_symbol(CMD_ENCODE, 16'h7fff, 1'b1);
        add_symbol(CMD_ENCODE, 16'h0000, 1'b0);
        add_symbol(CMD_FINISH, 16'h1234, 1'b0);
        add_symbol(CMD_FINISH, 16'h0000, 1'b1);
        n_directed = pending_symbols.size();

        // Random frames: encodes mostly drawn to match their probability, usually closed by a flush.
        while (pending_symbols.size() < n_directed + RANDOM_SYMBOLS) begin
            frame_len = $urandom_range(0, 24);
            for (int k = 0; k < frame_len; k++) begin
                case ($urandom_range(0, 15))
                    0:       prob = 0;
                    1:       prob = 16'hffff;
                    2:       prob = $urandom_range(1, 255);
                    3:       prob = $urandom_range(16'hff00, 16'hffff);
                    default: prob = $urandom_range(0, 16'hffff);
                endcase
                if ($urandom_range(0, 3) != 0)
                    bit_value = ($urandom_range(0, 16'hffff) < prob);
                else
                    bit_value = 1'($urandom_range(0, 1));
                add_symbol(CMD_ENCODE, prob, bit_value);
            end
            if ($urandom_range(0, 9) != 0)
                add_symbol(CMD_FINISH, $urandom_range(0, 16'hffff), 1'($urandom_range(0, 1)));
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_symbols.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
